>>> sv/mrg_pkg.sv
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared widths, register indexes and controller/datapath interface structs
// for the maze row generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mrg_pkg;

  localparam int unsigned LABEL_W    = 12;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned COLS_CFG_W = 6;
  localparam int unsigned ROWS_CFG_W = 7;
  localparam int unsigned WALL_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic start;         // input transfer, latch choices, clear masks
    logic idx_clr;       // restart the cell index
    logic ld_left;       // load left label from cell 0
    logic step_init;     // row 0: label one unlabeled cell
    logic step_right;    // right-wall pass, one neighbor pair
    logic step_close;    // last row: join one differing pair
    logic step_bottom;   // bottom-wall decision for one cell
    logic step_relabel;  // fresh label for one cell
    logic emit;          // load the output register
  } mrg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic single;        // one cell per row
    logic idx_last;      // index at last cell
    logic pair_end;      // index at last neighbor pair
    logic out_free;      // output register can take a result
  } mrg_sts_t;

endpackage

`default_nettype wire

>>> sv/mrg_ctrl.sv
// ----------------------------------------------------------------------------
// mrg_ctrl
// Sequencer for one maze row: optional row-0 labeling, right-wall pass,
// closing pass or bottom-wall and relabel passes, then result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_ctrl
  import mrg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire mrg_sts_t sts,
  output mrg_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INIT    = 9'b000000010,
    S_PRIME   = 9'b000000100,
    S_RIGHT   = 9'b000001000,
    S_CPRIME  = 9'b000010000,
    S_CLOSE   = 9'b000100000,
    S_BOTTOM  = 9'b001000000,
    S_RELABEL = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start   = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = sts.first_row ? S_INIT : S_PRIME;
        end
      end
      S_INIT: begin
        cmd.step_init = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.ld_left = 1'b1;
        cmd.idx_clr = 1'b1;
        if (sts.single) begin
          state_next = sts.last_row ? S_EMIT : S_BOTTOM;
        end else begin
          state_next = S_RIGHT;
        end
      end
      S_RIGHT: begin
        cmd.step_right = 1'b1;
        if (sts.pair_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = sts.last_row ? S_CPRIME : S_BOTTOM;
        end
      end
      S_CPRIME: begin
        cmd.ld_left = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.step_close = 1'b1;
        if (sts.pair_end) begin
          state_next = S_EMIT;
        end
      end
      S_BOTTOM: begin
        cmd.step_bottom = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_RELABEL;
        end
      end
      S_RELABEL: begin
        cmd.step_relabel = 1'b1;
        if (sts.idx_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/mrg_datapath.sv
// ----------------------------------------------------------------------------
// mrg_datapath
// Set-label cells with a parallel label match, label counter, row index,
// wall masks and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_datapath
  import mrg_pkg::*;
#(
  parameter int unsigned MAX_COLS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mrg_cmd_t                        cmd,
  output mrg_sts_t                             sts,
  input  wire logic [$clog2(MAX_COLS+1)-1:0]   n_cells,
  input  wire logic [ROWS_CFG_W-1:0]           n_rows,
  input  wire logic [WALL_W-1:0]               right_choices,
  input  wire logic [WALL_W-1:0]               bottom_choices,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [WALL_W-1:0]                    right_walls,
  output logic [WALL_W-1:0]                    bottom_walls,
  output logic [ROW_W-1:0]                     row_number,
  output logic                                 final_row
);

  localparam int unsigned NCOL_W = $clog2(MAX_COLS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_COLS);

  logic [LABEL_W-1:0]  labels [MAX_COLS];
  logic [LABEL_W-1:0]  next_label;
  logic [LABEL_W-1:0]  left_lab;
  logic [ROW_W-1:0]    row_index;
  logic [IDX_W-1:0]    idx;
  logic [MAX_COLS-1:0] rch, bch;
  logic [MAX_COLS-1:0] right_m, bottom_m;

  logic [NCOL_W-1:0]   n_dec;
  logic [IDX_W-1:0]    n_m1;
  logic [IDX_W-1:0]    idx_inc;
  logic [IDX_W-1:0]    rd_sel;
  logic [LABEL_W-1:0]  rd_data;
  logic [LABEL_W-1:0]  nl_inc;
  logic [MAX_COLS-1:0] cell_en, match, idx_bit, last_bit;
  logic [MAX_COLS-1:0] bot_set, bot_next;
  logic                last_row, wall, merge, init_wr, relabel_wr, multi;
  logic [WALL_W-1:0]   right_ext, bottom_ext;

  assign n_dec    = n_cells - NCOL_W'(1);
  assign n_m1     = n_dec[IDX_W-1:0];
  assign idx_inc  = idx + IDX_W'(1);
  assign last_row = ({1'b0, row_index} + ROWS_CFG_W'(1)) >= n_rows;
  assign nl_inc   = next_label + LABEL_W'(1);

  // pair passes look at the right-hand cell; left label is held in left_lab
  assign rd_sel  = (cmd.step_right || cmd.step_close) ? idx_inc : idx;
  assign rd_data = labels[rd_sel];

  assign idx_bit  = {{(MAX_COLS-1){1'b0}}, 1'b1} << idx;
  assign last_bit = {{(MAX_COLS-1){1'b0}}, 1'b1} << n_m1;

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      cell_en[j] = NCOL_W'(j) < n_cells;
      match[j]   = cell_en[j] && (labels[j] == rd_data);
    end
  end

  assign wall       = rch[idx] || (left_lab == rd_data);
  assign merge      = (cmd.step_right && !wall) ||
                      (cmd.step_close && (left_lab != rd_data));
  assign init_wr    = cmd.step_init && (rd_data == '0);
  assign relabel_wr = cmd.step_relabel && bottom_m[idx];

  // more than one cell in the set: clearing the lowest match leaves a bit
  assign multi    = |(match & (match - MAX_COLS'(1)));
  assign bot_set  = (bch[idx] && multi) ? (bottom_m | idx_bit) : bottom_m;
  assign bot_next = (|(match & ~bot_set)) ? bot_set : (bot_set & ~idx_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        labels[j] <= '0;
      end
      next_label <= '0;
      row_index  <= '0;
    end else begin
      for (int j = 0; j < MAX_COLS; j++) begin
        if (cmd.emit && last_row) begin
          labels[j] <= '0;
        end else if ((init_wr || relabel_wr) && IDX_W'(j) == idx) begin
          labels[j] <= nl_inc;
        end else if (merge && match[j]) begin
          labels[j] <= left_lab;
        end
      end
      if (cmd.emit && last_row) begin
        next_label <= '0;
      end else if (init_wr || cmd.step_relabel) begin
        next_label <= nl_inc;
      end
      if (cmd.emit) begin
        row_index <= last_row ? '0 : row_index + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.step_init || cmd.step_right || cmd.step_close ||
                 cmd.step_bottom || cmd.step_relabel) begin
      idx <= idx_inc;
    end
    if (cmd.ld_left || (cmd.step_right && wall)) begin
      left_lab <= rd_data;
    end
    if (cmd.start) begin
      rch      <= right_choices[MAX_COLS-1:0];
      bch      <= bottom_choices[MAX_COLS-1:0];
      right_m  <= '0;
      bottom_m <= '0;
    end else begin
      if (cmd.step_right && wall) begin
        right_m <= right_m | idx_bit;
      end else if (cmd.step_close && merge) begin
        right_m <= right_m & ~idx_bit;
      end
      if (cmd.step_bottom) begin
        bottom_m <= bot_next;
      end
    end
  end

  always_comb begin
    right_ext  = '0;
    bottom_ext = '0;
    right_ext[MAX_COLS-1:0]  = right_m | last_bit;
    bottom_ext[MAX_COLS-1:0] = last_row ? cell_en : bottom_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      right_walls  <= right_ext;
      bottom_walls <= bottom_ext;
      row_number   <= row_index;
      final_row    <= last_row;
    end
  end

  always_comb begin
    sts.first_row = (row_index == '0);
    sts.last_row  = last_row;
    sts.single    = (n_cells == NCOL_W'(1));
    sts.idx_last  = (idx == n_m1);
    sts.pair_end  = (idx_inc == n_m1);
    sts.out_free  = !out_valid || out_ready;
  end

  // closing the last row returns the labels, label counter and row index to reset values
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && last_row |=> row_index == '0 && next_label == '0)
    else $error("state not cleared after final row");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !last_row |=> row_index == $past(row_index) + ROW_W'(1))
    else $error("row index did not advance");

  // every pair joins into the set of cell 0 during the closing pass
  a_close_left: assert property (@(posedge clk) disable iff (rst)
    cmd.step_close |=> left_lab == $past(left_lab))
    else $error("left label moved during closing pass");

endmodule

`default_nettype wire

>>> sv/maze_row_generator.sv
// ----------------------------------------------------------------------------
// maze_row_generator
// Eller's maze generator: one input transfer of per-cell random bits yields
// one transfer of right and bottom wall masks for the next maze row. The
// block keeps a set label per cell, walks the cells one per cycle through a
// single label read port with a parallel label match, and after the last row
// (row count from rows_in_use) clears its state for a new maze. Each row runs
// a right-wall pass over neighbor pairs, then bottom-wall and relabel passes;
// row 0 first labels its unlabeled cells, and the last row runs a closing
// pass instead of the bottom-wall and relabel passes. The result sits
// in an output register, so the next item is taken while it waits.
// Configuration writes are taken at any time but belong between mazes or
// rows while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_row_generator
  import mrg_pkg::*;
#(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [WALL_W-1:0]     right_choices,
  input  wire logic [WALL_W-1:0]     bottom_choices,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [WALL_W-1:0]          right_walls,
  output logic [WALL_W-1:0]          bottom_walls,
  output logic [ROW_W-1:0]           row_number,
  output logic                       final_row
);

  localparam int unsigned NCOL_W = $clog2(MAX_COLS + 1);

  logic [COLS_CFG_W-1:0] cols_in_use;
  logic [ROWS_CFG_W-1:0] rows_in_use;
  logic [NCOL_W-1:0]     n_cells;
  logic [ROWS_CFG_W-1:0] n_rows;
  mrg_cmd_t              cmd;
  mrg_sts_t              sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_CFG_W'(32);
      rows_in_use <= ROWS_CFG_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLS_IN_USE: cols_in_use <= cfg_data[COLS_CFG_W-1:0];
        CFG_ROWS_IN_USE: rows_in_use <= cfg_data[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range counts clamp to 1..MAX
  always_comb begin
    if (cols_in_use == '0) begin
      n_cells = NCOL_W'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      n_cells = NCOL_W'(MAX_COLS);
    end else begin
      n_cells = NCOL_W'(cols_in_use);
    end
    if (rows_in_use == '0) begin
      n_rows = ROWS_CFG_W'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      n_rows = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      n_rows = rows_in_use;
    end
  end

  mrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrg_datapath #(
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .n_cells        (n_cells),
    .n_rows         (n_rows),
    .right_choices  (right_choices),
    .bottom_choices (bottom_choices),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .right_walls    (right_walls),
    .bottom_walls   (bottom_walls),
    .row_number     (row_number),
    .final_row      (final_row)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for maze_row_generator. A clocked driver feeds rows of
// random wall choices from a queue; a software copy of the generator predicts
// the wall masks of each row; a clocked monitor compares every output transfer
// against the oldest prediction. The block is reconfigured between phases,
// including mid-maze and with out-of-range settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import mrg_pkg::*;
();

  localparam int MAX_COLS    = 32;
  localparam int MAX_ROWS    = 64;
  localparam int STALL_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [WALL_W-1:0] rch;
    logic [WALL_W-1:0] bch;
  } choices_t;

  typedef struct packed {
    logic [WALL_W-1:0] right;
    logic [WALL_W-1:0] bottom;
    logic [ROW_W-1:0]  row;
    logic              fin;
  } row_walls_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [WALL_W-1:0]     right_choices = '0;
  logic [WALL_W-1:0]     bottom_choices = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [WALL_W-1:0]     right_walls;
  logic [WALL_W-1:0]     bottom_walls;
  logic [ROW_W-1:0]      row_number;
  logic                  final_row;

  // generator model state
  logic [LABEL_W-1:0]    cell_set [MAX_COLS];
  logic [LABEL_W-1:0]    label_ctr;
  logic [ROW_W-1:0]      cur_row;
  logic [COLS_CFG_W-1:0] cols_reg;
  logic [ROWS_CFG_W-1:0] rows_reg;

  choices_t   pending_choices [$];
  row_walls_t expected_walls [$];

  int   mismatch_count = 0;
  int   rows_queued = 0;
  int   idle_cycles = 0;
  logic calm = 1'b0;
  logic [2:0] send_gap = '0;
  logic [2:0] recv_gap = '0;

  maze_row_generator i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .right_choices  (right_choices),
    .bottom_choices (bottom_choices),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .right_walls    (right_walls),
    .bottom_walls   (bottom_walls),
    .row_number     (row_number),
    .final_row      (final_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_maze();
    int i;
    for (i = 0; i < MAX_COLS; i++) cell_set[i] = '0;
    label_ctr = '0;
    cur_row = '0;
  endfunction

  function automatic void merge_sets(input logic [LABEL_W-1:0] keep,
                                     input logic [LABEL_W-1:0] drop, input int n);
    int j;
    for (j = 0; j < n; j++)
      if (cell_set[j] == drop) cell_set[j] = keep;
  endfunction

  // Advances the model by one maze row and returns the walls it must produce.
  function automatic row_walls_t build_row(input logic [WALL_W-1:0] rch,
                                           input logic [WALL_W-1:0] bch);
    row_walls_t r;
    int n, rows, members, open_cells, i, j;
    logic [LABEL_W-1:0] lab;
    logic last;
    n = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
    rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
    last = (int'(cur_row) + 1 >= rows);
    r.right = '0;
    r.bottom = '0;
    r.row = cur_row;
    r.fin = last;
    if (cur_row == 0) begin
      for (i = 0; i < n; i++)
        if (cell_set[i] == 0) begin
          label_ctr = label_ctr + LABEL_W'(1);
          cell_set[i] = label_ctr;
        end
    end
    for (i = 0; i < n - 1; i++) begin
      if (rch[i] || cell_set[i] == cell_set[i+1]) r.right[i] = 1'b1;
      else merge_sets(cell_set[i], cell_set[i+1], n);
    end
    r.right[n-1] = 1'b1;
    if (last) begin
      // closing row: join every set still apart, floor is solid
      for (i = 0; i < n - 1; i++)
        if (cell_set[i] != cell_set[i+1]) begin
          r.right[i] = 1'b0;
          merge_sets(cell_set[i], cell_set[i+1], n);
        end
      for (i = 0; i < n; i++) r.bottom[i] = 1'b1;
      clear_maze();
    end else begin
      for (i = 0; i < n; i++) begin
        lab = cell_set[i];
        members = 0;
        for (j = 0; j < n; j++)
          if (cell_set[j] == lab) members++;
        if (bch[i] && members > 1) r.bottom[i] = 1'b1;
        // every set needs at least one passage down
        open_cells = 0;
        for (j = 0; j < n; j++)
          if (cell_set[j] == lab && !r.bottom[j]) open_cells++;
        if (open_cells == 0) r.bottom[i] = 1'b0;
      end
      for (i = 0; i < n; i++) begin
        label_ctr = label_ctr + LABEL_W'(1);
        if (r.bottom[i]) cell_set[i] = label_ctr;
      end
      cur_row = cur_row + ROW_W'(1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [WALL_W-1:0] got,
                                 input logic [WALL_W-1:0] want);
    if (mismatch_count < 100)
      $display("ERROR: %s got %h, want %h", field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cols_reg <= 6'd32;
      rows_reg <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLS_IN_USE: cols_reg <= cfg_data[COLS_CFG_W-1:0];
        CFG_ROWS_IN_USE: rows_reg <= cfg_data[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // driver
  always @(posedge clk) begin : drive_rows
    logic     nxt_valid;
    choices_t ch;
    if (rst) begin
      clear_maze();
      in_valid <= 1'b0;
      send_gap <= '0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        expected_walls.push_back(build_row(right_choices, bottom_choices));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 3'd1;
        end else if (pending_choices.size() != 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap <= 3'($urandom_range(0, 6));
          end else begin
            ch = pending_choices.pop_front();
            right_choices <= ch.rch;
            bottom_choices <= ch.bch;
            nxt_valid = 1'b1;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor
  always @(posedge clk) begin : check_rows
    row_walls_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_walls.size() == 0) begin
          report_mismatch("unexpected row transfer, row_number",
                          WALL_W'(row_number), '0);
        end else begin
          want = expected_walls.pop_front();
          if (right_walls !== want.right)
            report_mismatch("right_walls", right_walls, want.right);
          if (bottom_walls !== want.bottom)
            report_mismatch("bottom_walls", bottom_walls, want.bottom);
          if (row_number !== want.row)
            report_mismatch("row_number", WALL_W'(row_number), WALL_W'(want.row));
          if (final_row !== want.fin)
            report_mismatch("final_row", WALL_W'(final_row), WALL_W'(want.fin));
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 3'd1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap <= 3'($urandom_range(0, 6));
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: timeout, no transfer for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void queue_row(input logic [WALL_W-1:0] rch,
                                    input logic [WALL_W-1:0] bch);
    choices_t ch;
    ch.rch = rch;
    ch.bch = bch;
    pending_choices.push_back(ch);
    rows_queued++;
  endfunction

  // mix of densities so both merge-heavy and wall-heavy rows show up
  function automatic logic [WALL_W-1:0] random_bits();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom & $urandom;
      4, 5: return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_choices.size() != 0 || in_valid || expected_walls.size() != 0);
  endtask

  initial begin
    int count;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, first rows of a 32-wide maze
    queue_row('0, '0);
    queue_row('1, '1);
    queue_row(32'hAAAA_AAAA, 32'h5555_5555);
    queue_row(32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();
    // row count dropped below the current row: next row closes the maze
    write_reg(CFG_ROWS_IN_USE, 7'd2);
    queue_row(32'h0F0F_0F0F, 32'hFFFF_0000);
    wait_drained();
    write_reg(CFG_COLS_IN_USE, 7'd1);
    write_reg(CFG_ROWS_IN_USE, 7'd1);
    queue_row('1, '1);
    queue_row('0, '0);
    wait_drained();
    // zero acts as one for both registers
    write_reg(CFG_COLS_IN_USE, 7'd0);
    write_reg(CFG_ROWS_IN_USE, 7'd0);
    queue_row($urandom, $urandom);
    wait_drained();
    write_reg(CFG_COLS_IN_USE, 7'd4);
    write_reg(CFG_ROWS_IN_USE, 7'd3);
    queue_row('0, '1);
    wait_drained();
    // widen mid-maze: new cells are still unlabeled after row 0
    write_reg(CFG_COLS_IN_USE, 7'd8);
    queue_row(32'h0000_0010, 32'h0000_00F0);
    queue_row(32'h0000_0055, 32'h0000_00FF);
    wait_drained();
    write_reg(CFG_COLS_IN_USE, 7'd40);
    write_reg(CFG_ROWS_IN_USE, 7'd100);
    queue_row($urandom, $urandom);
    queue_row($urandom, '1);
    wait_drained();
    // bit 6 falls outside the column register; unmapped index is ignored
    write_reg(CFG_COLS_IN_USE, 7'h45);
    write_reg(CFG_UNMAPPED, 7'h7F);
    queue_row($urandom, $urandom);
    wait_drained();
    write_reg(CFG_COLS_IN_USE, 7'd32);
    write_reg(CFG_ROWS_IN_USE, 7'd2);
    queue_row('1, '0);
    queue_row('0, '1);
    queue_row($urandom, $urandom);
    wait_drained();

    // one full-size maze
    write_reg(CFG_COLS_IN_USE, 7'd32);
    write_reg(CFG_ROWS_IN_USE, 7'd64);
    count = MAX_ROWS - int'(cur_row);
    repeat (count) queue_row(random_bits(), random_bits());
    wait_drained();

    while (rows_queued < 440) begin
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_COLS_IN_USE, ($urandom_range(0, 7) == 0) ?
                  7'($urandom) : 7'($urandom_range(1, 32)));
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: write_reg(CFG_ROWS_IN_USE, 7'($urandom));
          1: write_reg(CFG_ROWS_IN_USE, 7'd64);
          default: write_reg(CFG_ROWS_IN_USE, 7'($urandom_range(1, 12)));
        endcase
      end
      if ($urandom_range(0, 15) == 0) write_reg(CFG_UNMAPPED, 7'($urandom));
      count = $urandom_range(4, 40);
      repeat (count) queue_row(random_bits(), random_bits());
      wait_drained();
    end

    // closing stretch at full rate
    calm = 1'b1;
    write_reg(CFG_COLS_IN_USE, 7'($urandom_range(1, 32)));
    write_reg(CFG_ROWS_IN_USE, 7'($urandom_range(2, 20)));
    repeat (60) queue_row(random_bits(), random_bits());
    wait_drained();
    repeat (4 * MAX_COLS + 50) @(posedge clk);

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/mrg_pkg.sv
sv/mrg_ctrl.sv
sv/mrg_datapath.sv
sv/maze_row_generator.sv
tb/sv/testbench.sv
